// File: hw/rtl/tdq_pkg.sv
// Package for the timer deadline queue: action, result and state codes and beat types.
// No dependencies.
package tdq_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_START_ACK = 2'd0,
    KIND_STOP_ACK  = 2'd1,
    KIND_FIRED     = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  slot;
    logic [30:0] interval;
    logic [15:0] repeat_count;
    logic        forever_req;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] slot_out;
    logic       status;
    logic       last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_FIRE,
    ST_FIRE_WAIT,
    ST_DONE
  } state_t;

endpackage

// File: hw/rtl/tdq_slot_ram.sv
// Slot memory of the timer deadline queue: one entry per timer slot.
// Depends on nothing but its parameters.
module tdq_slot_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 80
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/timer_deadline_queue.sv
// Top level of the timer deadline queue: command decode, due scan and firing.
// Depends on tdq_pkg and tdq_slot_ram.
// Start and stop go through ST_DONE, which registers their beat onto the result ports.
// A tick scans every slot through the memory read port, in states SCAN and SCAN_WAIT, and each fired
// slot adds the states FIRE and FIRE_WAIT and a further scan of all slots.
// Results cannot be stalled. Reset clears time, sequence and armed flags.
module timer_deadline_queue #(
  parameter int NUM_TIMERS = 16,
  parameter int TIME_BITS  = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  tdq_pkg::cmd_t    cmd,
  output logic             strobe,
  output tdq_pkg::result_t result
);

  localparam int AW = $clog2(NUM_TIMERS);
  localparam int EW = TIME_BITS + 31 + 16 + 1 + 32;
  localparam logic [TIME_BITS-1:0] HALF = {1'b1, {(TIME_BITS-1){1'b0}}};

  typedef struct packed {
    logic [TIME_BITS-1:0] deadline;
    logic [30:0]          period;
    logic [15:0]          repeats;
    logic                 always_on;
    logic [31:0]          stamp;
  } entry_t;

  tdq_pkg::state_t state, state_next;
  logic [TIME_BITS-1:0] now_ms;
  logic [31:0] arm_seq;
  logic [NUM_TIMERS-1:0] armed, fired_set;
  tdq_pkg::cmd_t c;
  logic [AW-1:0] idx;
  logic found;
  logic [AW-1:0] best;
  logic [TIME_BITS-1:0] best_el;
  logic [31:0] best_age;
  logic any_fired;
  logic strobe_next;

  logic we;
  logic [AW-1:0] waddr, raddr;
  entry_t wdata, rd;
  logic [EW-1:0] rdata;

  tdq_slot_ram #(.DEPTH(NUM_TIMERS), .WIDTH(EW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );
  assign rd = entry_t'(rdata);

  logic [TIME_BITS-1:0] el;
  logic [31:0] age;
  logic due, better, last_idx, slot_ok;
  assign el = now_ms - rd.deadline;
  assign age = arm_seq - rd.stamp;
  assign due = armed[idx] && !fired_set[idx] && el != '0 && el < HALF;
  assign better = !found || el > best_el || (el == best_el && age > best_age);
  assign last_idx = (idx == AW'(NUM_TIMERS - 1));
  assign slot_ok = (32'(c.slot) < 32'(NUM_TIMERS));

  always_comb begin
    state_next = state;
    case (state)
      tdq_pkg::ST_IDLE: begin
        if (start) begin
          if (cmd.action == tdq_pkg::ACT_NONE) state_next = tdq_pkg::ST_IDLE;
          else if (cmd.action == tdq_pkg::ACT_TICK) state_next = tdq_pkg::ST_SCAN;
          else state_next = tdq_pkg::ST_DONE;
        end
      end
      tdq_pkg::ST_SCAN: state_next = tdq_pkg::ST_SCAN_WAIT;
      tdq_pkg::ST_SCAN_WAIT: begin
        if (last_idx) state_next = found ? tdq_pkg::ST_FIRE :
                                   (due ? tdq_pkg::ST_FIRE : tdq_pkg::ST_DONE);
        else state_next = tdq_pkg::ST_SCAN;
      end
      tdq_pkg::ST_FIRE: state_next = tdq_pkg::ST_FIRE_WAIT;
      tdq_pkg::ST_FIRE_WAIT: state_next = tdq_pkg::ST_SCAN;
      tdq_pkg::ST_DONE: state_next = tdq_pkg::ST_IDLE;
      default: state_next = tdq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    raddr = idx;
    if (state == tdq_pkg::ST_FIRE) raddr = best;
    we = 1'b0;
    waddr = best;
    wdata = rd;
    wdata.deadline = now_ms + TIME_BITS'(rd.period);
    wdata.stamp = arm_seq;
    if (rd.repeats != 16'd0 && !rd.always_on) wdata.repeats = rd.repeats - 16'd1;
    if (state == tdq_pkg::ST_FIRE_WAIT) we = rd.always_on || rd.repeats != 16'd0;
    if (state == tdq_pkg::ST_DONE && c.action == tdq_pkg::ACT_START && slot_ok) begin
      we = 1'b1;
      waddr = AW'(c.slot);
      wdata.deadline = now_ms + TIME_BITS'(c.interval);
      wdata.period = c.interval;
      wdata.repeats = c.repeat_count;
      wdata.always_on = c.forever_req;
      wdata.stamp = arm_seq;
    end
  end

  assign strobe_next =
    (state == tdq_pkg::ST_SCAN_WAIT && last_idx && !found && !due && any_fired) ||
    (state == tdq_pkg::ST_FIRE && any_fired) ||
    (state == tdq_pkg::ST_DONE && c.action != tdq_pkg::ACT_TICK);

  assign busy = (state != tdq_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      state <= tdq_pkg::ST_IDLE;
      now_ms <= '0;
      arm_seq <= '0;
      armed <= '0;
    end else begin
      strobe <= strobe_next;
      state <= state_next;
      case (state)
        tdq_pkg::ST_IDLE: begin
          c <= cmd;
          idx <= '0;
          found <= 1'b0;
          fired_set <= '0;
          any_fired <= 1'b0;
          if (start && cmd.action == tdq_pkg::ACT_TICK) now_ms <= now_ms + 1'b1;
        end
        tdq_pkg::ST_SCAN_WAIT: begin
          if (due && better) begin
            found <= 1'b1;
            best <= idx;
            best_el <= el;
            best_age <= age;
          end
          idx <= last_idx ? '0 : idx + 1'b1;
          if (last_idx && !found && !due && any_fired) begin
            result.last <= 1'b1;
          end
        end
        tdq_pkg::ST_FIRE_WAIT: begin
          fired_set[best] <= 1'b1;
          found <= 1'b0;
          any_fired <= 1'b1;
          if (rd.always_on || rd.repeats != 16'd0) arm_seq <= arm_seq + 1'b1;
          else armed[best] <= 1'b0;
          result.kind <= tdq_pkg::KIND_FIRED;
          result.slot_out <= 4'(best);
          result.status <= 1'b0;
          result.last <= 1'b0;
        end
        tdq_pkg::ST_DONE: begin
          if (c.action != tdq_pkg::ACT_TICK) begin
            result.slot_out <= c.slot;
            result.last <= 1'b1;
            if (c.action == tdq_pkg::ACT_START) begin
              result.kind <= tdq_pkg::KIND_START_ACK;
              result.status <= 1'b0;
              if (slot_ok) begin
                armed[AW'(c.slot)] <= 1'b1;
                arm_seq <= arm_seq + 1'b1;
              end
            end else begin
              result.kind <= tdq_pkg::KIND_STOP_ACK;
              result.status <= !(slot_ok && armed[AW'(c.slot)]);
              if (slot_ok) armed[AW'(c.slot)] <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/tdq_checker.sv
// Port checker for the timer deadline queue, bound to the top level.
// Depends on tdq_pkg.
module tdq_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input tdq_pkg::result_t result,
  input logic             strobe
);

  a_idle_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || !strobe)
    else $error("beat right after an accept while idle");
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |-> busy)
    else $error("intermediate beat while idle");
  a_status: assert property (@(posedge clk) disable iff (rst)
    strobe && result.status |-> result.kind == tdq_pkg::KIND_STOP_ACK)
    else $error("bad status");
  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    strobe && result.kind != tdq_pkg::KIND_FIRED |-> result.last)
    else $error("ack not last");

endmodule

bind timer_deadline_queue tdq_checker u_chk (.*);
